// ===== rtl/nearest_center_assignment_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-centre assignment unit
// Shared assertion forms; the enclosing scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTER_ASSIGNMENT_UNIT_MACROS_SVH
`define NEAREST_CENTER_ASSIGNMENT_UNIT_MACROS_SVH

// same-cycle implication
`define NCA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NCA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nca_pkg.sv =====
// ----------------------------------------------------------------------------
// nca_pkg
// Shared types and constants for the nearest-centre assignment unit.
// ----------------------------------------------------------------------------
package nca_pkg;

	localparam int COORD_W         = 16;  // signed coordinate width
	localparam int DIFF_W          = COORD_W + 1;
	localparam int SQ_W            = 2 * DIFF_W;
	localparam int ACC_W           = 37;  // accumulator width (saturating)
	localparam int DIST_W          = 36;  // emitted distance width
	localparam int CIDX_FIELD_W    = 4;   // centre index field width
	localparam int DIDX_FIELD_W    = 4;   // dimension index field width
	localparam int CFG_W           = 5;   // configuration register width
	localparam int CNT_W           = 9;   // holds counts up to 256
	localparam int TOK_IDX_W       = 8;   // centre index carried on the token
	localparam int BEAT_DIDX_W     = 8;   // dimension index carried on a beat
	localparam int DEF_MAX_CENTERS = 16;
	localparam int DEF_MAX_DIMS    = 16;
	localparam int CFG_RESET       = 16;

	typedef enum logic [0:0] {
		CFG_CENTERS = 1'b0,
		CFG_DIMS    = 1'b1
	} cfg_reg_t;

	// beat travelling down the row of cells
	typedef struct packed {
		logic                     valid;
		logic                     is_wr;    // centre coordinate write
		logic                     is_acc;   // point coordinate, in range
		logic                     is_last;  // closes the point
		logic [CIDX_FIELD_W-1:0]  cidx;
		logic [BEAT_DIDX_W-1:0]   didx;
		logic [COORD_W-1:0]       value;
	} beat_t;

	// running best candidate handed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic [TOK_IDX_W-1:0] idx;
		logic [ACC_W-1:0]     sq_dist;
	} token_t;

endpackage

// ===== rtl/nca_cell.sv =====
// ----------------------------------------------------------------------------
// nca_cell
// One centre: holds its coordinates and distance accumulator, passes the
// beat on each cycle while enabled and merges its distance into the running best.
// ----------------------------------------------------------------------------
module nca_cell #(
	parameter int MAX_DIMS = nca_pkg::DEF_MAX_DIMS,
	parameter int CELL_ID  = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [nca_pkg::CNT_W-1:0]  nc,
	input  nca_pkg::beat_t             beat_in,
	input  nca_pkg::token_t            tok_in,
	output nca_pkg::beat_t             beat_out,
	output nca_pkg::token_t            tok_out
);
	import nca_pkg::*;

	localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	logic [COORD_W-1:0] mem [MAX_DIMS];
	logic [DIDX_W-1:0]  addr;
	logic               wr_hit;
	logic               rd_req;
	logic               active;

	beat_t              beat_s1;
	logic [COORD_W-1:0] rd_s1;
	logic               acc_s2, last_s2;
	logic [DIFF_W-1:0]  diff_s2;
	logic               acc_s3, last_s3;
	logic [SQ_W-1:0]    sq_s3;
	logic [ACC_W-1:0]   acc_q;
	token_t             tok_q;

	logic signed [DIFF_W-1:0] diff_d;
	logic [ACC_W:0]           sum;
	logic [ACC_W-1:0]         acc_new;
	logic                     take_mine;

	assign addr   = DIDX_W'(beat_in.didx);
	assign wr_hit = beat_in.valid && beat_in.is_wr &&
		({{(CNT_W-CIDX_FIELD_W){1'b0}}, beat_in.cidx} == CNT_W'(CELL_ID));
	assign rd_req = beat_in.valid && beat_in.is_acc;
	assign active = CNT_W'(CELL_ID) < nc;

	// coordinate store, registered read
	always_ff @(posedge clk) begin
		if (en && wr_hit) begin
			mem[addr] <= beat_in.value;
		end
		if (en && rd_req) begin
			rd_s1 <= mem[addr];
		end
	end

	// beat register, also the hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
		end else if (en) begin
			beat_s1 <= beat_in;
		end
	end

	assign beat_out = beat_s1;

	// absolute difference
	assign diff_d = $signed({beat_s1.value[COORD_W-1], beat_s1.value}) -
		$signed({rd_s1[COORD_W-1], rd_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else if (en) begin
			acc_s2  <= beat_s1.valid && beat_s1.is_acc;
			last_s2 <= beat_s1.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2 <= diff_d[DIFF_W-1] ? DIFF_W'(-diff_d) : DIFF_W'(diff_d);
		end
	end

	// square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else if (en) begin
			acc_s3  <= acc_s2;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= diff_s2 * diff_s2;
		end
	end

	// saturating accumulate and compare against the incoming best
	always_comb begin
		sum       = {1'b0, acc_q} + (ACC_W+1)'(sq_s3);
		acc_new   = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
		take_mine = active && (!tok_in.valid || (acc_new < tok_in.sq_dist));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			tok_q <= '0;
		end else if (en) begin
			if (acc_s3 && last_s3) begin
				acc_q <= '0;
				if (take_mine) begin
					tok_q.valid   <= 1'b1;
					tok_q.idx     <= TOK_IDX_W'(CELL_ID);
					tok_q.sq_dist <= acc_new;
				end else begin
					tok_q <= tok_in;
				end
			end else begin
				tok_q.valid <= 1'b0;
				if (acc_s3 && active) begin
					acc_q <= acc_new;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/nearest_center_assignment_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_center_assignment_unit
// Nearest-centre search for k-means assignment over a stored codebook.
// ----------------------------------------------------------------------------
// A beat with tuser 0 stores one centre coordinate; a beat with tuser 1 is one
// point coordinate. Each beat runs down a row of MAX_CENTERS cells, one per
// centre, moving one cell per cycle while the row is enabled; every active cell
// squares its own difference and accumulates it, and on the beat that closes
// the point the running best (index, distance) is handed from cell to cell,
// lowest index winning ties. One beat is taken per cycle while the input is
// ready; a result passes the entry register, the row of cells with their read,
// difference, square and accumulate steps, and the output register. The input
// stalls only while a finished result waits at the output and another one
// reaches the end of the row. Reading a centre coordinate that was never
// written gives an undefined distance.
module nearest_center_assignment_unit #(
	parameter int MAX_CENTERS = nca_pkg::DEF_MAX_CENTERS,
	parameter int MAX_DIMS    = nca_pkg::DEF_MAX_DIMS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // center_index[3:0], dim_index[7:4], coord_value[23:8]
	input  logic        s_axis_tuser,   // kind
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // nearest_center[3:0], min_distance[39:4]
);
	import nca_pkg::*;

	logic [CFG_W-1:0] centers_q, dims_q;
	logic [CNT_W-1:0] nc, nd;
	logic             en;

	logic [CIDX_FIELD_W-1:0] in_cidx;
	logic [DIDX_FIELD_W-1:0] in_didx;
	logic [CNT_W-1:0]        cidx_ext, didx_ext;
	beat_t                   beat_d, beat_q;

	beat_t  beat_chain [MAX_CENTERS+1];
	token_t tok_chain  [MAX_CENTERS+1];
	token_t tok_end;

	logic                out_valid_q;
	logic [3:0]          out_center_q;
	logic [DIST_W-1:0]   out_dist_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centers_q <= CFG_W'(CFG_RESET);
			dims_q    <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CENTERS: centers_q <= cfg_data;
				CFG_DIMS:    dims_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	// effective counts: zero counts as one, clamp to the maximum
	always_comb begin
		if (centers_q == '0) begin
			nc = CNT_W'(1);
		end else if (CNT_W'(centers_q) > CNT_W'(MAX_CENTERS)) begin
			nc = CNT_W'(MAX_CENTERS);
		end else begin
			nc = CNT_W'(centers_q);
		end
		if (dims_q == '0) begin
			nd = CNT_W'(1);
		end else if (CNT_W'(dims_q) > CNT_W'(MAX_DIMS)) begin
			nd = CNT_W'(MAX_DIMS);
		end else begin
			nd = CNT_W'(dims_q);
		end
	end

	// decode the incoming beat
	assign in_cidx  = s_axis_tdata[3:0];
	assign in_didx  = s_axis_tdata[7:4];
	assign cidx_ext = CNT_W'(in_cidx);
	assign didx_ext = CNT_W'(in_didx);

	always_comb begin
		beat_d.valid   = s_axis_tvalid;
		beat_d.is_wr   = !s_axis_tuser && (cidx_ext < CNT_W'(MAX_CENTERS)) &&
			(didx_ext < CNT_W'(MAX_DIMS));
		beat_d.is_acc  = s_axis_tuser && (didx_ext < nd);
		beat_d.is_last = s_axis_tuser && (didx_ext == (nd - CNT_W'(1)));
		beat_d.cidx    = in_cidx;
		beat_d.didx    = BEAT_DIDX_W'(in_didx);
		beat_d.value   = s_axis_tdata[23:8];
	end

	// row advances unless a result at the end would find the output full
	assign tok_end       = tok_chain[MAX_CENTERS];
	assign en            = !(tok_end.valid && out_valid_q && !m_axis_tready);
	assign s_axis_tready = en;

	// entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (en) begin
			beat_q <= beat_d;
		end
	end

	assign beat_chain[0] = beat_q;
	assign tok_chain[0]  = '0;

	// row of centre cells
	for (genvar c = 0; c < MAX_CENTERS; c++) begin : g_cell
		nca_cell #(
			.MAX_DIMS (MAX_DIMS),
			.CELL_ID  (c)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.nc       (nc),
			.beat_in  (beat_chain[c]),
			.tok_in   (tok_chain[c]),
			.beat_out (beat_chain[c+1]),
			.tok_out  (tok_chain[c+1])
		);
	end

	// output register, distance saturated to the field width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= tok_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_valid_q || m_axis_tready) && tok_end.valid) begin
			out_center_q <= tok_end.idx[3:0];
			out_dist_q   <= tok_end.sq_dist[ACC_W-1] ? {DIST_W{1'b1}} :
				tok_end.sq_dist[DIST_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_dist_q, out_center_q};

endmodule

// ===== rtl/nca_checker.sv =====
// ----------------------------------------------------------------------------
// nca_checker
// Port-level checks on the nearest-centre assignment unit, bound to the top.
// ----------------------------------------------------------------------------
`include "nearest_center_assignment_unit_macros.svh"

module nca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// a stalled result stays offered
	`NCA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

	// and keeps its payload
	`NCA_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

	// input back-pressure only comes from a blocked output
	`NCA_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

	// an empty output never holds the input off
	`NCA_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind nearest_center_assignment_unit nca_checker u_nca_checker (.*);
